// ----- design/i2c_master_pin_sequencer_core_defines.svh -----
// assertion macros for the i2c master pin sequencer checker
// no dependencies; included by the checker file only
`ifndef I2C_MASTER_PIN_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_PIN_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define I2CPS_ASSERT_NOW(label, clk, rst_n, cond, concl) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (concl)) \
        else $error("i2cps check failed");

// next-cycle implication, disabled while reset is asserted
`define I2CPS_ASSERT_NEXT(label, clk, rst_n, cond, concl) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (concl)) \
        else $error("i2cps check failed");

`endif

// ----- design/i2cps_pkg.sv -----
// types, codes and the pin step decoder of the i2c master pin sequencer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package i2cps_pkg;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic PIN_SCL = 1'b0;
    localparam logic PIN_SDA = 1'b1;

    localparam logic [1:0] PH0 = 2'd0;
    localparam logic [1:0] PH1 = 2'd1;
    localparam logic [1:0] PH2 = 2'd2;
    localparam logic [1:0] PH3 = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic [7:0] slave_bits;
        logic       slave_ack_level;
    } cmd_t;

    typedef struct packed {
        logic       pin_sel;
        logic       pin_level;
        logic       ack_ok;
        logic [7:0] read_data;
        logic       last;
    } res_t;

    // classified command as held in the queue
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       ack_ok;
        logic [7:0] read_data;
    } task_t;

    // queue head seen by the back end
    typedef struct packed {
        logic  valid;
        task_t head;
    } head_t;

    typedef struct packed {
        logic pin_sel;
        logic pin_level;
        logic last;
        logic wrap;
    } step_t;

    // one pin write; bit_idx 8 is the ack slot, wrap moves to the next bit
    function automatic step_t step_decode(input logic [1:0] op, input logic [7:0] tx_byte,
                                          input logic [3:0] bit_idx, input logic [1:0] phase);
        step_t s;
        s = '0;
        case (op)
            OP_START:
            begin
                s.pin_sel   = (phase == PH0 || phase == PH3) ? PIN_SCL : PIN_SDA;
                s.pin_level = (phase == PH0 || phase == PH1);
                s.last      = (phase == PH3);
            end
            OP_STOP:
            begin
                s.pin_sel   = (phase == PH1) ? PIN_SCL : PIN_SDA;
                s.pin_level = (phase != PH0);
                s.last      = (phase == PH2);
            end
            OP_WRITE:
            begin
                s.pin_sel   = (phase == PH0) ? PIN_SDA : PIN_SCL;
                if (phase == PH0)
                begin
                    s.pin_level = bit_idx[3] ? 1'b1 : tx_byte[~bit_idx[2:0]];
                end
                else
                begin
                    s.pin_level = (phase == PH1);
                end
                s.last = bit_idx[3] && (phase == PH2);
                s.wrap = !bit_idx[3] && (phase == PH2);
            end
            OP_READ:
            begin
                if (!bit_idx[3])
                begin
                    s.pin_sel   = PIN_SCL;
                    s.pin_level = (phase == PH0);
                    s.wrap      = (phase == PH1);
                end
                else
                begin
                    s.pin_sel   = (phase == PH0) ? PIN_SDA : PIN_SCL;
                    s.pin_level = (phase == PH1);
                    s.last      = (phase == PH2);
                end
            end
            default:
            begin
                s = '0;
            end
        endcase
        return s;
    endfunction

endpackage

// ----- design/i2cps_front.sv -----
// front end: classifies an incoming command into a queue entry
// depends on i2cps_pkg
`timescale 1ns / 1ps

module i2cps_front
(
    input  i2cps_pkg::cmd_t  cmd,
    output i2cps_pkg::task_t task_out
);

    always_comb
    begin
        task_out.op        = cmd.op;
        task_out.tx_byte   = cmd.tx_byte;
        // flags only matter for the command that reports them
        task_out.ack_ok    = (cmd.op == i2cps_pkg::OP_WRITE) && !cmd.slave_ack_level;
        task_out.read_data = (cmd.op == i2cps_pkg::OP_READ) ? cmd.slave_bits : 8'h00;
    end

endmodule

// ----- design/i2cps_queue.sv -----
// short command queue between front and back end
// depends on i2cps_pkg
`timescale 1ns / 1ps

module i2cps_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  i2cps_pkg::task_t  wr_data,
    output logic              full,
    input  logic              rd_en,
    output i2cps_pkg::head_t  head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    i2cps_pkg::task_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full       = (count_reg == FULL_CNT);
    assign head.valid = (count_reg != '0);
    assign head.head  = mem_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !full;
    assign do_rd      = rd_en && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- design/i2cps_back.sv -----
// back end: steps through the pin writes of the queue head into an output register
// depends on i2cps_pkg
`timescale 1ns / 1ps

module i2cps_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  i2cps_pkg::head_t  head,
    output logic              head_pop,
    output logic              empty,
    input  logic              pop,
    output i2cps_pkg::res_t   res
);

    logic [3:0]        bit_reg, bit_next;
    logic [1:0]        phase_reg, phase_next;
    logic              res_valid_reg, res_valid_next;
    i2cps_pkg::res_t   res_reg, res_next;
    i2cps_pkg::step_t  step;
    logic              out_free, advance;

    assign step     = i2cps_pkg::step_decode(head.head.op, head.head.tx_byte,
                                             bit_reg, phase_reg);
    assign out_free = !res_valid_reg || pop;
    assign advance  = head.valid && out_free;
    assign head_pop = advance && step.last;
    assign empty    = !res_valid_reg;
    assign res      = res_reg;

    always_comb
    begin
        bit_next       = bit_reg;
        phase_next     = phase_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (out_free)
        begin
            res_valid_next = head.valid;
        end
        if (advance)
        begin
            res_next.pin_sel   = step.pin_sel;
            res_next.pin_level = step.pin_level;
            res_next.last      = step.last;
            res_next.ack_ok    = step.last && head.head.ack_ok;
            res_next.read_data = step.last ? head.head.read_data : 8'h00;
            if (step.last)
            begin
                bit_next   = '0;
                phase_next = '0;
            end
            else if (step.wrap)
            begin
                bit_next   = bit_reg + 1'b1;
                phase_next = '0;
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg       <= '0;
            phase_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            bit_reg       <= bit_next;
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ----- design/i2c_master_pin_sequencer_core.sv -----
// top level of the i2c master pin sequencer: front end, command queue, back end
// depends on i2cps_pkg, i2cps_front, i2cps_queue, i2cps_back
//
// channel   direction  handshake          payload
// command   in         push / full        cmd  (i2cps_pkg::cmd_t)
// pin write out        empty / pop        res  (i2cps_pkg::res_t)
//
// one pin write leaves per cycle while the output is not held: start 4, stop 3, write byte 27,
// read byte 19 pin writes, set by the back end's bit/phase step counter; commands follow with no gap
// a pushed command is registered in the queue, then each of its pin writes in the output register
// QUEUE_DEPTH commands wait between front and back; full rises when all are taken
// a held result stalls only the back end; the queue keeps accepting until full
// reset clears the queue and the output register, payload is not reset
`timescale 1ns / 1ps

module i2c_master_pin_sequencer_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  i2cps_pkg::cmd_t  cmd,
    output logic             empty,
    input  logic             pop,
    output i2cps_pkg::res_t  res
);

    i2cps_pkg::task_t task_in;
    i2cps_pkg::head_t head;
    logic             head_pop;

    i2cps_front u_front
    (
        .cmd      (cmd),
        .task_out (task_in)
    );

    i2cps_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (task_in),
        .full    (full),
        .rd_en   (head_pop),
        .head    (head)
    );

    i2cps_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .head_pop (head_pop),
        .empty    (empty),
        .pop      (pop),
        .res      (res)
    );

endmodule

// ----- design/i2cps_checker.sv -----
// port-level checks for the i2c master pin sequencer, bound to the top level
// depends on i2cps_pkg and i2c_master_pin_sequencer_core_defines.svh
`timescale 1ns / 1ps
`include "i2c_master_pin_sequencer_core_defines.svh"

module i2cps_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             empty,
    input logic             pop,
    input i2cps_pkg::res_t  res
);

    logic shown;
    logic flags_clear;
    logic ends_idle;
    logic ack_alone;

    assign shown       = !empty;
    assign flags_clear = !res.ack_ok && (res.read_data == 8'h00);
    assign ends_idle   = (res.pin_sel == i2cps_pkg::PIN_SCL && !res.pin_level)
                      || (res.pin_sel == i2cps_pkg::PIN_SDA && res.pin_level);
    assign ack_alone   = (res.read_data == 8'h00) && (res.pin_sel == i2cps_pkg::PIN_SCL);

    // a waiting result stays and holds its value
    `I2CPS_ASSERT_NEXT(a_res_hold, clk, rst_n, shown && !pop, !empty && $stable(res))

    // flags stay zero until the final write of a command
    `I2CPS_ASSERT_NOW(a_flags_last, clk, rst_n, shown && !res.last, flags_clear)

    // every command ends on scl low or sda released
    `I2CPS_ASSERT_NOW(a_last_pin, clk, rst_n, shown && res.last, ends_idle)

    // ack and read data never come together
    `I2CPS_ASSERT_NOW(a_flag_excl, clk, rst_n, shown && res.ack_ok, ack_alone)

endmodule

bind i2c_master_pin_sequencer_core i2cps_checker u_i2cps_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .empty (empty),
    .pop   (pop),
    .res   (res)
);
